[src/multi_queue_shared_buffer_defines.svh]
// Assertion macros for the checker file of the multi-queue buffer.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqsb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MQSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqsb: next-cycle check failed");

`endif

[src/mqsb_pkg.sv]
// Shared types and constants of the multi-queue shared buffer.
// No dependencies; imported by the RTL modules and the checker.
package mqsb_pkg;

  localparam int DATA_W = 32;
  localparam int QID_W  = 2;

  localparam logic                OP_ENQ   = 1'b0;
  localparam logic                OP_DEQ   = 1'b1;
  localparam logic [DATA_W-1:0]   MOST_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage

[src/multi_queue_shared_buffer.sv]
// An enqueue or any rejected operation reaches out_tvalid after the queue-table read; a good
// dequeue also waits on the slot-store read, and both wait longer while an earlier result stalls
// at out. One operation is in flight at a time, so a new one is taken only after the last one's
// result is registered at out. A new transaction is taken while the previous result waits at
// out. Reset (synchronous, rst_n low) empties every queue and chains all slots on the free list
// in order, with no clearing pass.
module multi_queue_shared_buffer import mqsb_pkg::*; #(
  parameter int SLOTS  = 16,
  parameter int QUEUES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [2:0]  in_tuser,   // [0] op, [2:1] queue_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int IW = $clog2(SLOTS);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SLOT} state_t;

  state_t            state_r;
  logic              op_r;
  logic              q_ok_r;
  logic [QW-1:0]     qidx_r;
  logic [DATA_W-1:0] data_r;
  logic              free_nil_r;
  logic [IW-1:0]     free_idx_r;
  logic [IW:0]       fresh_cnt_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;

  logic              in_acc, out_free;
  logic              in_op;
  logic [QID_W-1:0]  in_qid;
  logic              in_q_ok;

  logic              slot_rd_en;
  logic [IW-1:0]     slot_rd_addr;
  logic [DATA_W-1:0] slot_rd_data;
  logic [IW:0]       slot_rd_link;
  logic              link_we;
  logic [IW-1:0]     link_waddr;
  logic [IW:0]       link_wdata;

  logic [IW-1:0]     qt_head, qt_tail;
  logic              qt_valid;
  logic              qt_we;
  logic [IW-1:0]     qt_whead;
  logic              qt_wvalid;

  logic              q_empty, deq_go, enq_go, deq_fin, look_fin;
  logic              slot_fresh;
  logic [IW:0]       fresh_inc;
  logic [IW:0]       free_nxt;

  assign in_op   = in_tuser[0];
  assign in_qid  = in_tuser[2:1];
  assign in_q_ok = (int'(in_qid) < QUEUES);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign q_empty  = !q_ok_r || !qt_valid;
  assign deq_go   = (state_r == S_LOOK) && (op_r == OP_DEQ) && !q_empty;
  assign look_fin = (state_r == S_LOOK) && !deq_go && out_free;
  assign enq_go   = look_fin && (op_r == OP_ENQ) && q_ok_r && !free_nil_r;
  assign deq_fin  = (state_r == S_SLOT) && out_free;

  // Slots at or above the fill count were never handed out and still chain in order.
  assign slot_fresh = ({1'b0, free_idx_r} >= fresh_cnt_r);
  assign fresh_inc  = {1'b0, free_idx_r} + (IW+1)'(1);
  always_comb begin
    if (slot_fresh) begin
      free_nxt = {fresh_inc == (IW+1)'(SLOTS), fresh_inc[IW-1:0]};
    end else begin
      free_nxt = slot_rd_link;
    end
  end

  // The read at acceptance fetches the free head's link; a dequeue then reads its head slot.
  assign slot_rd_en   = in_acc || deq_go;
  assign slot_rd_addr = (state_r == S_IDLE) ? free_idx_r : qt_head;

  // A tail slot's link is never followed, so an enqueue only patches the old tail.
  assign link_we    = (enq_go && qt_valid) || deq_fin;
  assign link_waddr = deq_fin ? qt_head : qt_tail;
  assign link_wdata = deq_fin ? {free_nil_r, free_idx_r} : {1'b0, free_idx_r};

  assign qt_we     = enq_go || deq_fin;
  assign qt_whead  = deq_fin ? slot_rd_link[IW-1:0] : (qt_valid ? qt_head : free_idx_r);
  assign qt_wvalid = deq_fin ? (qt_head != qt_tail) : 1'b1;

  mqsb_slot_mem #(.SLOTS(SLOTS)) u_slot_mem (
    .clk        (clk),
    .rd_en      (slot_rd_en),
    .rd_addr    (slot_rd_addr),
    .rd_data    (slot_rd_data),
    .rd_link    (slot_rd_link),
    .data_we    (enq_go),
    .data_waddr (free_idx_r),
    .data_wdata (data_r),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata)
  );

  mqsb_queue_mem #(.QUEUES(QUEUES), .SLOTS(SLOTS)) u_queue_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (QW'(in_qid)),
    .rd_head  (qt_head),
    .rd_tail  (qt_tail),
    .rd_valid (qt_valid),
    .we       (qt_we),
    .waddr    (qidx_r),
    .whead    (qt_whead),
    .wtail    (deq_fin ? qt_tail : free_idx_r),
    .wvalid   (qt_wvalid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_nil_r  <= 1'b0;
      free_idx_r  <= '0;
      fresh_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !look_fin && !deq_fin) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (deq_go) begin
            state_r <= S_SLOT;
          end else if (look_fin) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (op_r == OP_ENQ) begin
              out_data_r   <= '0;
              out_status_r <= enq_go ? ST_OK : ST_OVERFLOW;
            end else begin
              out_data_r   <= MOST_NEG;
              out_status_r <= ST_EMPTY;
            end
            if (enq_go) begin
              {free_nil_r, free_idx_r} <= free_nxt;
              if (slot_fresh) begin
                fresh_cnt_r <= fresh_inc;
              end
            end
          end
        end
        S_SLOT: begin
          if (deq_fin) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_data_r   <= slot_rd_data;
            out_status_r <= ST_OK;
            free_nil_r   <= 1'b0;
            free_idx_r   <= qt_head;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      q_ok_r <= in_q_ok;
      qidx_r <= QW'(in_qid);
      data_r <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

[src/mqsb_slot_mem.sv]
// Slot store: data words and next-slot links, one read port each.
// Depends on mqsb_pkg for the data width.
module mqsb_slot_mem import mqsb_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data,
  output logic [IW:0]       rd_link,
  input  logic              data_we,
  input  logic [IW-1:0]     data_waddr,
  input  logic [DATA_W-1:0] data_wdata,
  input  logic              link_we,
  input  logic [IW-1:0]     link_waddr,
  input  logic [IW:0]       link_wdata
);

  logic [DATA_W-1:0] data_mem [SLOTS];
  // Bit IW of a link marks the null pointer.
  logic [IW:0]       link_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (rd_en) begin
      rd_data <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end

endmodule

[src/mqsb_queue_mem.sv]
// Queue table: head and tail slot of every queue, plus a nonempty flag per queue.
// Depends on mqsb_pkg only through the common import style.
module mqsb_queue_mem import mqsb_pkg::*; #(
  parameter int QUEUES = 4,
  parameter int SLOTS  = 16,
  localparam int IW = $clog2(SLOTS),
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [QW-1:0] rd_addr,
  output logic [IW-1:0] rd_head,
  output logic [IW-1:0] rd_tail,
  output logic          rd_valid,
  input  logic          we,
  input  logic [QW-1:0] waddr,
  input  logic [IW-1:0] whead,
  input  logic [IW-1:0] wtail,
  input  logic          wvalid
);

  logic [2*IW-1:0] ptr_mem [QUEUES];
  logic            qv_r [QUEUES];

  always_ff @(posedge clk) begin
    if (we) begin
      ptr_mem[waddr] <= {whead, wtail};
    end
    if (rd_en) begin
      {rd_head, rd_tail} <= ptr_mem[rd_addr];
    end
  end

  // The flags clear on reset, so the pointer words need no clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        qv_r[i] <= 1'b0;
      end
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        qv_r[waddr] <= wvalid;
      end
      if (rd_en) begin
        rd_valid <= qv_r[rd_addr];
      end
    end
  end

endmodule

[src/mqsb_checker.sv]
// Port-level checker for the multi-queue shared buffer, bound to the top level.
// Depends on mqsb_pkg and the assertion macros in multi_queue_shared_buffer_defines.svh.
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_checker import mqsb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic [33:0] out_word;
  logic        status_legal;

  assign out_word     = {out_tuser, out_tdata};
  // Overflow comes only from an enqueue, whose data is zero; no other status codes appear.
  assign status_legal = (out_tuser == ST_OK) || (out_tuser == ST_EMPTY) ||
                        ((out_tuser == ST_OVERFLOW) && (out_tdata == '0));

  // A stalled result keeps its contents.
  `MQSB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // Only one operation is in flight, so the input closes right after a transaction.
  `MQSB_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

  // An empty dequeue returns the most negative value.
  `MQSB_ASSERT_NOW(a_empty_value, out_tvalid && out_tuser == ST_EMPTY, out_tdata == MOST_NEG)

  `MQSB_ASSERT_NOW(a_status_code, out_tvalid, status_legal)

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
